// ===== design/ladder_lowpass_4pole_tpt_assert.svh =====
// Assertion macros for the ladder lowpass block.
// Depends on signals named clk and arst_n in the module that uses them.
`ifndef LADDER_LOWPASS_4POLE_TPT_ASSERT_SVH
`define LADDER_LOWPASS_4POLE_TPT_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define LTP_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("ladder lowpass: same-cycle check failed");

// Check that a condition implies another in the next cycle
`define LTP_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("ladder lowpass: next-cycle check failed");

`endif

// ===== design/ltp_pkg.sv =====
// Shared widths, register indexes and saturation helpers for the ladder lowpass.
// No dependencies; used by the channel interfaces and the top level.
package ltp_pkg;

	// field and coefficient formats
	localparam int SAMPLE_WIDTH   = 24;
	localparam int COEF_FRAC_BITS = 18;
	localparam int RES_FRAC_BITS  = 16;
	localparam int REG_W          = 19;
	localparam int MEM_W          = 32;

	// register file
	localparam int NUM_REGS  = 7;
	localparam int CFG_IDX_W = $clog2(NUM_REGS + 1);

	localparam logic [CFG_IDX_W-1:0] REG_STAGE_GAIN   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ONE   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TWO   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_THREE = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FOUR  = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_RESONANCE    = CFG_IDX_W'(6);

	localparam logic [REG_W-1:0] RST_STAGE_GAIN  = REG_W'(31000);
	localparam logic [REG_W-1:0] RST_INPUT_SCALE = REG_W'(262144);
	localparam logic [REG_W-1:0] RST_WEIGHT_FOUR = REG_W'(262144);

	// datapath widths
	// multiplicand: widest operand is sample minus resonance term (below 2^39)
	localparam int MUL_A_W = 40;
	localparam int ACC_W   = MUL_A_W + 1;
	localparam int PROD_W  = ACC_W + REG_W;
	localparam int FB_W    = MEM_W + REG_W + 2;
	localparam int FBR_W   = FB_W - COEF_FRAC_BITS + 1;
	localparam int RND_W   = PROD_W - COEF_FRAC_BITS + 1;
	localparam int R16_W   = PROD_W - RES_FRAC_BITS + 1;
	localparam int DIF_W   = MEM_W + 1;
	localparam int CNT_W   = $clog2(REG_W);

	// clamp a wide value to the stage memory range
	function automatic logic signed [MEM_W-1:0] sat_mem(input logic signed [RND_W-1:0] v);
		logic [RND_W-MEM_W:0] top;
		top = v[RND_W-1:MEM_W-1];
		if ((&top) || !(|top))
			return v[MEM_W-1:0];
		else if (v[RND_W-1])
			return {1'b1, {(MEM_W-1){1'b0}}};
		else
			return {1'b0, {(MEM_W-1){1'b1}}};
	endfunction

	// clamp a stage value to the sample range
	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
		input logic signed [MEM_W-1:0] v
	);
		logic [MEM_W-SAMPLE_WIDTH:0] top;
		top = v[MEM_W-1:SAMPLE_WIDTH-1];
		if ((&top) || !(|top))
			return v[SAMPLE_WIDTH-1:0];
		else if (v[MEM_W-1])
			return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		else
			return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	endfunction

endpackage

// ===== design/ltp_if.sv =====
// Valid/ready channels of the ladder lowpass: input samples, filtered samples,
// register writes. Depends on ltp_pkg.
interface ltp_in_if;
	import ltp_pkg::*;
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	modport source(output valid, output sample_in, input ready);
	modport sink(input valid, input sample_in, output ready);
endinterface

interface ltp_out_if;
	import ltp_pkg::*;
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	modport source(output valid, output sample_out, input ready);
	modport sink(input valid, input sample_out, output ready);
endinterface

interface ltp_cfg_if;
	import ltp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [REG_W-1:0]     reg_data;
	modport source(output valid, output reg_index, output reg_data, input ready);
	modport sink(input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== design/ladder_lowpass_4pole_tpt.sv =====
// Channel       | Dir | Payload                       | Beat taken when
// sample_ch     | in  | sample_in, 24 bit signed      | valid & ready
// filtered_ch   | out | sample_out, 24 bit signed     | valid & ready
// cfg_ch        | in  | reg_index 3 bit, reg_data 19  | valid (ready held high)
//
// One serial-parallel multiplier takes one coefficient bit per cycle; every
// sample runs ten products through it (four feedback weights, resonance, input
// scale, four stage gains), each stage gain product followed by stage update in
// S_ADDY and S_ADDS. A new sample is accepted only in idle, once the previous one
// has left the final step; one result is buffered, so an output stall only delays
// the next sample while the previous result is still waiting at the final step.
// Reset loads the register defaults and clears the four stage memories.
// Depends on ltp_pkg, ltp_if and ladder_lowpass_4pole_tpt_assert.svh.
`include "ladder_lowpass_4pole_tpt_assert.svh"

module ladder_lowpass_4pole_tpt (
	input logic        clk,
	input logic        arst_n,
	ltp_in_if.sink     sample_ch,
	ltp_out_if.source  filtered_ch,
	ltp_cfg_if.sink    cfg_ch
);
	import ltp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_MUL, S_RND, S_ADDY, S_ADDS, S_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_FB1, OP_FB2, OP_FB3, OP_FB4, OP_RES, OP_IN,
		OP_ST1, OP_ST2, OP_ST3, OP_ST4
	} op_t;

	state_t state_q;
	op_t    op_q;
	logic [CNT_W-1:0] bit_cnt_q;
	logic             out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_data_q;

	logic [REG_W-1:0]        cfg_q [NUM_REGS];
	logic signed [MEM_W-1:0] mem_q [4];

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [MUL_A_W-1:0]      a_q;
	logic [REG_W-1:0]               b_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic [REG_W-1:0]               lo_q;
	logic signed [FB_W-1:0]         fb_q;
	logic signed [MUL_A_W-1:0]      r_q;
	logic signed [MEM_W-1:0]        v_q;
	logic signed [MEM_W-1:0]        y_q;

	logic                      sample_acc;
	logic                      out_load;
	logic                      is_stage;
	logic [1:0]                mem_idx;
	logic signed [MEM_W-1:0]   mem_sel;
	logic signed [MUL_A_W-1:0] opnd;
	logic [REG_W-1:0]          coef;
	logic signed [FBR_W-1:0]   fb_rnd;
	logic signed [ACC_W-1:0]   addend;
	logic signed [ACC_W-1:0]   psum;
	logic signed [PROD_W-1:0]  prod;
	logic signed [RND_W-1:0]   p18;
	logic signed [R16_W-1:0]   p16;

	// handshakes
	assign sample_acc        = sample_ch.valid && sample_ch.ready;
	assign sample_ch.ready   = (state_q == S_IDLE);
	assign cfg_ch.ready      = 1'b1;
	assign filtered_ch.valid = out_valid_q;
	assign filtered_ch.sample_out = out_data_q;

	// pick the stage memory and coefficient for the current product
	assign is_stage = (op_q >= OP_ST1);
	assign mem_idx  = is_stage ? 2'(op_q - OP_ST1) : 2'(op_q - OP_FB1);
	assign mem_sel  = mem_q[mem_idx];
	assign fb_rnd   = FBR_W'($signed(fb_q[FB_W-1:COEF_FRAC_BITS]))
		+ FBR_W'({1'b0, fb_q[COEF_FRAC_BITS-1]});

	always_comb begin
		unique case (op_q)
			OP_FB1, OP_FB2, OP_FB3, OP_FB4: begin
				opnd = MUL_A_W'(mem_sel);
				coef = cfg_q[REG_WEIGHT_ONE + CFG_IDX_W'(mem_idx)];
			end
			OP_RES: begin
				opnd = MUL_A_W'(fb_rnd);
				coef = cfg_q[REG_RESONANCE];
			end
			OP_IN: begin
				opnd = MUL_A_W'(x_q) - r_q;
				coef = cfg_q[REG_INPUT_SCALE];
			end
			OP_ST1, OP_ST2, OP_ST3, OP_ST4: begin
				opnd = MUL_A_W'(DIF_W'(y_q) - DIF_W'(mem_sel));
				coef = cfg_q[REG_STAGE_GAIN];
			end
			default: begin
				opnd = '0;
				coef = '0;
			end
		endcase
	end

	// one multiplier step: add multiplicand on a set coefficient bit, then halve
	assign addend = b_q[0] ? ACC_W'(a_q) : '0;
	assign psum   = acc_q + addend;
	assign prod   = $signed({acc_q, lo_q});

	// round half up at the two scale points
	assign p18 = RND_W'($signed(prod[PROD_W-1:COEF_FRAC_BITS]))
		+ RND_W'({1'b0, prod[COEF_FRAC_BITS-1]});
	assign p16 = R16_W'($signed(prod[PROD_W-1:RES_FRAC_BITS]))
		+ R16_W'({1'b0, prod[RES_FRAC_BITS-1]});

	// load the output register once the previous beat is gone or leaves now
	assign out_load = (state_q == S_OUT) && (!out_valid_q || filtered_ch.ready);

	// sequencer, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_FB1;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// take a fresh result, else drop the beat once it is taken
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= sat_sample(y_q);
			end else if (filtered_ch.valid && filtered_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (sample_acc) begin
					state_q <= S_LOAD;
					op_q    <= OP_FB1;
				end
				S_LOAD: begin
					bit_cnt_q <= '0;
					state_q   <= S_MUL;
				end
				S_MUL: if (bit_cnt_q == CNT_W'(REG_W - 1)) begin
					bit_cnt_q <= '0;
					state_q   <= S_RND;
				end else begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
				end
				S_RND: if (is_stage) begin
					state_q <= S_ADDY;
				end else begin
					op_q    <= op_t'(op_q + 1'b1);
					state_q <= S_LOAD;
				end
				S_ADDY: state_q <= S_ADDS;
				S_ADDS: if (op_q == OP_ST4) begin
					state_q <= S_OUT;
				end else begin
					op_q    <= op_t'(op_q + 1'b1);
					state_q <= S_LOAD;
				end
				S_OUT: if (out_load) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// register file; writes beyond the last register drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_STAGE_GAIN]   <= RST_STAGE_GAIN;
			cfg_q[REG_INPUT_SCALE]  <= RST_INPUT_SCALE;
			cfg_q[REG_WEIGHT_ONE]   <= '0;
			cfg_q[REG_WEIGHT_TWO]   <= '0;
			cfg_q[REG_WEIGHT_THREE] <= '0;
			cfg_q[REG_WEIGHT_FOUR]  <= RST_WEIGHT_FOUR;
			cfg_q[REG_RESONANCE]    <= '0;
		end else if (cfg_ch.valid && cfg_ch.ready
				&& cfg_ch.reg_index < CFG_IDX_W'(NUM_REGS)) begin
			cfg_q[cfg_ch.reg_index[CFG_IDX_W-1:0]] <= cfg_ch.reg_data;
		end
	end

	// stage memories: update after the second stage add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				mem_q[i] <= '0;
		end else if (state_q == S_ADDS) begin
			mem_q[mem_idx] <= sat_mem(RND_W'(DIF_W'(v_q) + DIF_W'(y_q)));
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (sample_acc)
			x_q <= sample_ch.sample_in;
		unique case (state_q)
			S_LOAD: begin
				a_q   <= opnd;
				b_q   <= coef;
				acc_q <= '0;
			end
			S_MUL: begin
				acc_q <= {psum[ACC_W-1], psum[ACC_W-1:1]};
				lo_q  <= {psum[0], lo_q[REG_W-1:1]};
				b_q   <= {1'b0, b_q[REG_W-1:1]};
			end
			S_RND: begin
				unique case (op_q)
					OP_FB1:                 fb_q <= FB_W'(prod);
					OP_FB2, OP_FB3, OP_FB4: fb_q <= fb_q + FB_W'(prod);
					OP_RES:                 r_q  <= MUL_A_W'(p16);
					OP_IN:                  y_q  <= sat_mem(p18);
					default:                v_q  <= sat_mem(p18);
				endcase
			end
			S_ADDY: y_q <= sat_mem(RND_W'(DIF_W'(v_q) + DIF_W'(mem_sel)));
			default: ;
		endcase
	end

	// checks
	`LTP_ASSERT_NEXT(a_start_fb, sample_acc, (state_q == S_LOAD && op_q == OP_FB1))
	`LTP_ASSERT_NEXT(a_mul_len, (state_q == S_MUL && bit_cnt_q == CNT_W'(REG_W - 1)), (state_q == S_RND))
	`LTP_ASSERT_IMP(a_out_loaded, (state_q == S_IDLE && $past(state_q) == S_OUT), out_valid_q)
	`LTP_ASSERT_IMP(a_stage_post, (state_q == S_ADDY || state_q == S_ADDS), is_stage)

endmodule
